### hw/rtl/cbh_pkg.sv
// ----------------------------------------------------------------------------
// cbh_pkg
// Types, constants and bucket-pick helper shared by the bucket hash pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cbh_pkg;

  localparam int unsigned DIV_CELLS = 64;
  localparam int unsigned LATENCY   = DIV_CELLS + 4;

  localparam logic [31:0] NARROW_LIMIT = 32'd32768;
  localparam logic [31:0] WIDE_LIMIT   = 32'h8000_0000;

  localparam logic REG_WIDE_MODE    = 1'b0;
  localparam logic REG_BUCKET_COUNT = 1'b1;

  typedef struct packed {
    logic        err;
    logic        zero_out;
    logic        fits;
    logic [4:0]  k;
    logic [30:0] cand;
    logic [30:0] alt;
  } side_t;

  // Power-of-two scheme for 2^p buckets.
  function automatic logic [30:0] pow2_pick(logic [31:0] a, logic [31:0] b,
                                            logic [31:0] c, logic [4:0] p);
    logic [32:0] m;
    logic [31:0] cbits;
    logic [31:0] top;
    logic [31:0] pick;
    logic [31:0] r;
    m     = (33'd1 << p) - 33'd1;
    cbits = c & m[31:0];
    top   = 32'd0;
    for (int i = 0; i < 32; i++) begin
      if (cbits[i]) top = 32'd1 << i;
    end
    pick = (^cbits) ? b : a;
    if (cbits < 32'd2) r = cbits;
    else r = top | (pick & (top - 32'd1));
    return r[30:0];
  endfunction

endpackage

### hw/rtl/cbh_front.sv
// ----------------------------------------------------------------------------
// cbh_front
// Splits the key, finds k, runs the power-of-two picks, packs the upper key
// bits and forms the modulus cand*(cand+1) over three register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbh_front import cbh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [63:0] key_low,
  input  logic [63:0] key_high,
  input  logic        wide_mode,
  input  logic [31:0] bucket_count,
  output logic        out_valid,
  output side_t       out_side,
  output logic [63:0] out_dvd,
  output logic [63:0] out_div
);

  // stage A
  logic        va;
  logic        err_a;
  logic        one_a;
  logic        wide_a;
  logic [4:0]  k_a;
  logic [31:0] a_a, b_a, c_a, d_a;
  logic [31:0] nm1;
  logic [4:0]  k_next;
  logic        err_next;

  always_comb begin
    nm1    = bucket_count - 32'd1;
    k_next = 5'd0;
    for (int i = 0; i < 31; i++) begin
      if (nm1[i]) k_next = 5'(i + 1);
    end
    err_next = (bucket_count == 32'd0) ||
               (bucket_count > (wide_mode ? WIDE_LIMIT : NARROW_LIMIT));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= in_valid;
    end
    err_a  <= err_next;
    one_a  <= (bucket_count == 32'd1);
    wide_a <= wide_mode;
    k_a    <= k_next;
    if (wide_mode) begin
      a_a <= key_low[31:0];
      b_a <= key_low[63:32];
      c_a <= key_high[31:0];
      d_a <= key_high[63:32];
    end else begin
      a_a <= {16'd0, key_low[15:0]};
      b_a <= {16'd0, key_low[31:16]};
      c_a <= {16'd0, key_low[47:32]};
      d_a <= {16'd0, key_low[63:48]};
    end
  end

  // stage B
  logic        vb;
  side_t       side_b;
  logic [63:0] pack_b;
  logic [30:0] cand_next;
  logic [5:0]  sh;
  logic [31:0] lead;
  logic [63:0] pk;
  logic [4:0]  km1;

  always_comb begin
    km1       = k_a - 5'd1;
    cand_next = pow2_pick(a_a, b_a, c_a, k_a);
    sh        = (wide_a ? 6'd32 : 6'd16) - {1'b0, k_a};
    lead      = (d_a << sh) | (c_a >> k_a);
    pk        = {32'd0, lead} << (sh + 6'd1);
    pk        = pk | {32'd0, b_a >> km1};
    pk        = pk << (sh + 6'd1);
    pk        = pk | {32'd0, a_a >> km1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
    side_b.err      <= err_a;
    side_b.zero_out <= err_a | one_a;
    side_b.fits     <= ({1'b0, cand_next} < bucket_count);
    side_b.k        <= k_a;
    side_b.cand     <= cand_next;
    side_b.alt      <= pow2_pick(a_a, b_a, c_a, km1);
    pack_b          <= pk;
  end

  // stage C
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vb;
    end
    out_side <= side_b;
    out_dvd  <= pack_b;
    out_div  <= {33'd0, side_b.cand} * ({33'd0, side_b.cand} + 64'd1);
  end

endmodule

### hw/rtl/cbh_div_cell.sv
// ----------------------------------------------------------------------------
// cbh_div_cell
// One restoring step of the remainder chain: take in one dividend bit,
// subtract the modulus when it fits, hand on to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbh_div_cell import cbh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  side_t       in_side,
  input  logic [63:0] in_rem,
  input  logic [63:0] in_dvd,
  input  logic [63:0] in_div,
  output logic        out_valid,
  output side_t       out_side,
  output logic [63:0] out_rem,
  output logic [63:0] out_dvd,
  output logic [63:0] out_div
);

  logic [63:0] trial;

  assign trial = {in_rem[62:0], in_dvd[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_side <= in_side;
    out_rem  <= (trial >= in_div) ? trial - in_div : trial;
    out_dvd  <= {in_dvd[62:0], 1'b0};
    out_div  <= in_div;
  end

endmodule

### hw/rtl/consistent_bucket_hash_top.sv
// ----------------------------------------------------------------------------
// consistent_bucket_hash_top
// Consistent bucket hash: maps a 64- or 128-bit hashed key to a bucket.
// ----------------------------------------------------------------------------
// channel   | ports                                  | handshake
// request   | start, busy, key_low, key_high         | taken when start & !busy
// result    | done, bucket, count_error              | one-cycle strobe
// config    | psel penable pwrite paddr pwdata prdata | APB, pready tied high
//
// One request per cycle; busy is never raised. A request passes through
// three front stages, 64 remainder cells (one dividend bit each) and the
// output stage. Reset clears all valid flags and sets wide_mode to 0 and
// bucket_count to 1. The receiver cannot stall results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module consistent_bucket_hash_top import cbh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] key_low,
  input  logic [63:0] key_high,
  output logic        done,
  output logic [30:0] bucket,
  output logic        count_error,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        wide_mode;
  logic [31:0] bucket_count;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign prdata = (paddr[2] == REG_BUCKET_COUNT) ? bucket_count : {31'd0, wide_mode};

  always_ff @(posedge clk) begin
    if (rst) begin
      wide_mode    <= 1'b0;
      bucket_count <= 32'd1;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_WIDE_MODE) wide_mode <= pwdata[0];
      else bucket_count <= pwdata;
    end
  end

  logic        v   [0:DIV_CELLS];
  side_t       sd  [0:DIV_CELLS];
  logic [63:0] rem [0:DIV_CELLS];
  logic [63:0] dvd [0:DIV_CELLS];
  logic [63:0] dv  [0:DIV_CELLS];

  cbh_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (start && !busy),
    .key_low      (key_low),
    .key_high     (key_high),
    .wide_mode    (wide_mode),
    .bucket_count (bucket_count),
    .out_valid    (v[0]),
    .out_side     (sd[0]),
    .out_dvd      (dvd[0]),
    .out_div      (dv[0])
  );

  assign rem[0] = 64'd0;

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
    cbh_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v[i]),
      .in_side   (sd[i]),
      .in_rem    (rem[i]),
      .in_dvd    (dvd[i]),
      .in_div    (dv[i]),
      .out_valid (v[i+1]),
      .out_side  (sd[i+1]),
      .out_rem   (rem[i+1]),
      .out_dvd   (dvd[i+1]),
      .out_div   (dv[i+1])
    );
  end

  side_t       sf;
  logic [63:0] large2;
  logic [30:0] res;

  always_comb begin
    sf     = sd[DIV_CELLS];
    large2 = (rem[DIV_CELLS] >> sf.k) + (64'd1 << (sf.k - 5'd1));
    if (sf.zero_out) res = 31'd0;
    else if (sf.fits) res = sf.cand;
    else if (large2 < {32'd0, bucket_count}) res = large2[30:0];
    else res = sf.alt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v[DIV_CELLS];
    end
    bucket      <= res;
    count_error <= sf.err;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done) else $error("result missing");

  a_range: assert property (@(posedge clk) disable iff (rst)
    (done && !count_error) |-> ({1'b0, bucket} < bucket_count))
    else $error("bucket out of range");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && count_error) |-> (bucket == 31'd0)) else $error("error bucket nonzero");

endmodule
